/* src/ptil_pkg.sv */
// Shared types and constants for the polar table lookup block.
`default_nettype none
package ptil_pkg;

  localparam int SPEED_W = 16;
  localparam int ANGLE_W = 16;
  localparam int TIME_W  = 20;
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;
  // Entry word: angle above time.
  localparam int ENTRY_W = ANGLE_W + TIME_W;
  // Interpolation product: 17-bit signed delta x times 21-bit signed delta y.
  localparam int PROD_W  = (SPEED_W + 1) + (TIME_W + 1);
  localparam int MAG_W   = PROD_W - 1;
  localparam int DCNT_W  = $clog2(MAG_W);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    REQ_INSERT,
    REQ_QUERY,
    REQ_CLEAR,
    REQ_NOP
  } req_kind_t;

  typedef struct packed {
    req_kind_t           kind;
    logic [SPEED_W-1:0]  speed;
    logic [ANGLE_W-1:0]  angle;
    logic [TIME_W-1:0]   value;
  } req_t;

endpackage
`default_nettype wire

/* src/ptil_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ptil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

/* src/ptil_front.sv */
// Front end: accepts requests, decodes the operation and queues them.
`default_nettype none
module ptil_front
  import ptil_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [OP_W-1:0]    in_operation,
  input  wire logic [SPEED_W-1:0] in_wind_speed,
  input  wire logic [ANGLE_W-1:0] in_wind_angle,
  input  wire logic [TIME_W-1:0]  in_entry_time,
  output logic                    req_valid,
  input  wire logic               req_pop,
  output req_t                    req
);

  req_t       q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  req_t       dec;
  logic       push;

  always_comb begin
    dec.speed = in_wind_speed;
    dec.angle = in_wind_angle;
    dec.value = in_entry_time;
    unique case (in_operation)
      OP_INSERT: dec.kind = REQ_INSERT;
      OP_QUERY:  dec.kind = REQ_QUERY;
      OP_CLEAR:  dec.kind = REQ_CLEAR;
      default:   dec.kind = REQ_NOP;
    endcase
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign req_valid = (cnt_r != 2'd0);
  assign req       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        q_r[wp_r] <= dec;
        wp_r      <= ~wp_r;
      end
      if (req_pop && req_valid) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(req_pop && req_valid);
    end
  end

endmodule
`default_nettype wire

/* src/ptil_engine.sv */
// Back end: sequencer that searches, edits and interpolates the table.
`default_nettype none
module ptil_engine
  import ptil_pkg::*;
#(
  parameter int MAX_ROWS            = 16,
  parameter int MAX_ENTRIES_PER_ROW = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              req_valid,
  output logic                   req_pop,
  input  req_t                   req,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [TIME_W-1:0]      out_result_time,
  output logic [ST_W-1:0]        out_status
);

  localparam int RW    = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = $clog2(MAX_ROWS + 1);
  localparam int EW    = $clog2(MAX_ENTRIES_PER_ROW + 1);
  localparam int DEPTH = MAX_ROWS * MAX_ENTRIES_PER_ROW;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_QROW, S_ERD, S_ECMP, S_EDONE,
    S_IROW, S_IRSHIFT, S_IERD, S_IECMP, S_IECHK, S_IESHIFT, S_IEWR,
    S_LMUL, S_LDIV, S_LFIN, S_LRET, S_OUT
  } state_t;

  state_t state_r;

  logic [SPEED_W-1:0] row_speed_r  [MAX_ROWS];
  logic [EW-1:0]      row_length_r [MAX_ROWS];
  logic [RW-1:0]      ord_r        [MAX_ROWS];
  logic [CW-1:0]      count_r;

  req_t               cur_r;
  logic [CW-1:0]      ri_r;
  logic [CW-1:0]      kr_r;
  logic [RW-1:0]      er_r;
  logic [EW-1:0]      ei_r;
  logic [EW-1:0]      ke_r;
  logic [RW-1:0]      prev_ord_r;
  logic [SPEED_W-1:0] prev_spd_r;
  logic               two_r;
  logic               phase_r;
  logic [ANGLE_W-1:0] pa_r;
  logic [TIME_W-1:0]  pv_r;
  logic [TIME_W-1:0]  ey_r;
  logic [TIME_W-1:0]  y1_r;

  logic [SPEED_W-1:0] lx1_r, lx2_r, lx_r;
  logic [TIME_W-1:0]  ly1_r, ly2_r, lres_r;
  logic               lkind_r;
  logic               neg_r;
  logic [SPEED_W-1:0] dx_r;
  logic [SPEED_W-1:0] rem_r;
  logic [MAG_W-1:0]   q_r;
  logic [DCNT_W-1:0]  dcnt_r;

  logic [TIME_W-1:0]  res_r;
  logic [ST_W-1:0]    st_r;

  // Table reads
  logic [RW-1:0]       ord_idx;
  logic [RW-1:0]       ord_rd;
  logic [SPEED_W-1:0]  spd_rd;
  logic [EW-1:0]       len_er;
  logic [EW-1:0]       rd_idx;
  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [ENTRY_W-1:0]  wdata, rdata;
  logic [ANGLE_W-1:0]  ra;
  logic [TIME_W-1:0]   rv;

  // Interpolation datapath
  logic [SPEED_W:0]    dxs;
  logic [TIME_W:0]     dys;
  logic [PROD_W-1:0]   prod;
  logic [SPEED_W-1:0]  dx;
  logic [SPEED_W:0]    rem_sh;
  logic                qbit;

  assign ord_idx = (state_r == S_IRSHIFT) ? RW'(kr_r - CW'(1)) : ri_r[RW-1:0];
  assign ord_rd  = ord_r[ord_idx];
  assign spd_rd  = row_speed_r[ord_rd];
  assign len_er  = row_length_r[er_r];
  assign rd_idx  = (state_r == S_IESHIFT) ? (ke_r - EW'(1)) : ei_r;
  assign raddr   = AW'(32'(er_r) * MAX_ENTRIES_PER_ROW + 32'(rd_idx));
  assign ra      = rdata[ENTRY_W-1:TIME_W];
  assign rv      = rdata[TIME_W-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = AW'(32'(er_r) * MAX_ENTRIES_PER_ROW + 32'(ei_r));
    wdata = {cur_r.angle, cur_r.value};
    if (state_r == S_IEWR) begin
      we    = 1'b1;
      waddr = AW'(32'(er_r) * MAX_ENTRIES_PER_ROW + 32'(ke_r));
      wdata = rdata;
    end else if (state_r == S_IESHIFT && !(ke_r > ei_r)) begin
      we = 1'b1;
    end
  end

  ptil_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_entries (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign dxs    = {1'b0, lx_r} - {1'b0, lx1_r};
  assign dys    = {1'b0, ly2_r} - {1'b0, ly1_r};
  assign prod   = PROD_W'($signed(dxs) * $signed(dys));
  assign dx     = lx2_r - lx1_r;
  assign rem_sh = {rem_r, q_r[MAG_W-1]};
  assign qbit   = (rem_sh >= {1'b0, dx_r});

  assign req_pop = (state_r == S_IDLE) && req_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state_r != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            cur_r <= req;
            res_r <= '0;
            st_r  <= (req.kind == REQ_QUERY && count_r == '0) ? ST_EMPTY : ST_OK;
            ri_r  <= '0;
            unique case (req.kind)
              REQ_INSERT: state_r <= S_IROW;
              REQ_QUERY: begin
                if (count_r == '0) begin
                  state_r <= S_OUT;
                end else begin
                  state_r <= S_QROW;
                end
              end
              REQ_CLEAR: begin
                count_r <= '0;
                state_r <= S_OUT;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end

        // Walk rows in speed order until the bracketing row is found.
        S_QROW: begin
          if ((ri_r + CW'(1)) < count_r && spd_rd < cur_r.speed) begin
            prev_ord_r <= ord_rd;
            prev_spd_r <= spd_rd;
            ri_r       <= ri_r + CW'(1);
          end else begin
            phase_r <= 1'b0;
            ei_r    <= '0;
            state_r <= S_ERD;
            if (spd_rd == cur_r.speed || ri_r == '0 ||
                ((ri_r + CW'(1)) == count_r && spd_rd < cur_r.speed)) begin
              two_r <= 1'b0;
              er_r  <= ord_rd;
            end else begin
              two_r <= 1'b1;
              er_r  <= prev_ord_r;
            end
          end
        end

        S_ERD: state_r <= S_ECMP;

        S_ECMP: begin
          if ((ei_r + EW'(1)) < len_er && ra < cur_r.angle) begin
            pa_r    <= ra;
            pv_r    <= rv;
            ei_r    <= ei_r + EW'(1);
            state_r <= S_ERD;
          end else if (ra == cur_r.angle || ei_r == '0 ||
                       ((ei_r + EW'(1)) == len_er && ra < cur_r.angle)) begin
            ey_r    <= rv;
            state_r <= S_EDONE;
          end else begin
            lx1_r   <= pa_r;
            lx2_r   <= ra;
            ly1_r   <= pv_r;
            ly2_r   <= rv;
            lx_r    <= cur_r.angle;
            lkind_r <= 1'b0;
            state_r <= S_LMUL;
          end
        end

        S_EDONE: begin
          if (!two_r) begin
            res_r   <= ey_r;
            state_r <= S_OUT;
          end else if (!phase_r) begin
            y1_r    <= ey_r;
            phase_r <= 1'b1;
            er_r    <= ord_rd;
            ei_r    <= '0;
            state_r <= S_ERD;
          end else begin
            lx1_r   <= prev_spd_r;
            lx2_r   <= spd_rd;
            ly1_r   <= y1_r;
            ly2_r   <= ey_r;
            lx_r    <= cur_r.speed;
            lkind_r <= 1'b1;
            state_r <= S_LMUL;
          end
        end

        // Insert: find the row, creating it in order when the speed is new.
        S_IROW: begin
          if (ri_r < count_r && spd_rd < cur_r.speed) begin
            ri_r <= ri_r + CW'(1);
          end else if (ri_r < count_r && spd_rd == cur_r.speed) begin
            er_r    <= ord_rd;
            ei_r    <= '0;
            state_r <= S_IERD;
          end else if (count_r == CW'(MAX_ROWS)) begin
            st_r    <= ST_FULL;
            state_r <= S_OUT;
          end else begin
            kr_r    <= count_r;
            state_r <= S_IRSHIFT;
          end
        end

        S_IRSHIFT: begin
          if (kr_r > ri_r) begin
            ord_r[kr_r[RW-1:0]] <= ord_rd;
            kr_r                <= kr_r - CW'(1);
          end else begin
            ord_r[ri_r[RW-1:0]]           <= RW'(count_r);
            row_speed_r[RW'(count_r)]  <= cur_r.speed;
            row_length_r[RW'(count_r)] <= '0;
            count_r                       <= count_r + CW'(1);
            er_r                          <= RW'(count_r);
            ei_r                          <= '0;
            state_r                       <= S_IERD;
          end
        end

        S_IERD: begin
          state_r <= (ei_r < len_er) ? S_IECMP : S_IECHK;
        end

        S_IECMP: begin
          if (ra < cur_r.angle) begin
            ei_r    <= ei_r + EW'(1);
            state_r <= S_IERD;
          end else if (ra == cur_r.angle) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_IECHK;
          end
        end

        S_IECHK: begin
          if (len_er == EW'(MAX_ENTRIES_PER_ROW)) begin
            st_r    <= ST_FULL;
            state_r <= S_OUT;
          end else begin
            ke_r    <= len_er;
            state_r <= S_IESHIFT;
          end
        end

        // Move entries up one slot, then drop the new one in its place.
        S_IESHIFT: begin
          if (ke_r > ei_r) begin
            state_r <= S_IEWR;
          end else begin
            row_length_r[er_r] <= len_er + EW'(1);
            state_r            <= S_OUT;
          end
        end

        S_IEWR: begin
          ke_r    <= ke_r - EW'(1);
          state_r <= S_IESHIFT;
        end

        S_LMUL: begin
          if (dx == '0) begin
            lres_r  <= ly2_r;
            state_r <= S_LRET;
          end else begin
            dx_r    <= dx;
            neg_r   <= prod[PROD_W-1];
            q_r     <= prod[PROD_W-1] ? MAG_W'(-prod) : prod[MAG_W-1:0];
            rem_r   <= '0;
            dcnt_r  <= '0;
            state_r <= S_LDIV;
          end
        end

        // Restoring division, one quotient bit per cycle.
        S_LDIV: begin
          rem_r  <= qbit ? SPEED_W'(rem_sh - {1'b0, dx_r}) : rem_sh[SPEED_W-1:0];
          q_r    <= {q_r[MAG_W-2:0], qbit};
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (dcnt_r == DCNT_W'(MAG_W - 1)) begin
            state_r <= S_LFIN;
          end
        end

        S_LFIN: begin
          lres_r  <= neg_r ? (ly1_r - q_r[TIME_W-1:0]) : (ly1_r + q_r[TIME_W-1:0]);
          state_r <= S_LRET;
        end

        S_LRET: begin
          if (lkind_r) begin
            res_r   <= lres_r;
            state_r <= S_OUT;
          end else begin
            ey_r    <= lres_r;
            state_r <= S_EDONE;
          end
        end

        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            out_result_time <= res_r;
            out_status      <= st_r;
            state_r         <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/polar_table_interpolated_lookup_top.sv */
// Top level of the polar table lookup: request queue front end and table engine.
//
// Usage: requests enter on the in_ channel (valid/ready) and carry an
// operation (insert, query, clear), a wind speed, a wind angle and an entry
// time. Every request yields exactly one response on the out_ channel with a
// time per mile and a status (ok, empty table, insert dropped as full).
// A two-deep request queue takes requests while the engine works, so in_ready
// only drops when two requests are waiting behind the one in progress.
// The engine handles one request at a time. A query walks the rows in
// speed order, reads entries from the entry RAM for each row evaluated
// (one or two rows), and runs each interpolation (up to three) in the
// shared bit-serial divider. An insert walks the rows, reorders rows when
// the speed is new, compares entries and moves entries up in the entry RAM.
// Reset empties the table at once; no clearing pass is needed.
// When the receiver holds out_ready low the response is held in the output
// register and the engine waits once its next response is ready; the
// queue keeps taking requests until full.
`default_nettype none
module polar_table_interpolated_lookup_top
  import ptil_pkg::*;
#(
  parameter int MAX_ROWS            = 16,
  parameter int MAX_ENTRIES_PER_ROW = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [OP_W-1:0]    in_operation,
  input  wire logic [SPEED_W-1:0] in_wind_speed,
  input  wire logic [ANGLE_W-1:0] in_wind_angle,
  input  wire logic [TIME_W-1:0]  in_entry_time,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [TIME_W-1:0]       out_result_time,
  output logic [ST_W-1:0]         out_status
);

  // Decoded request handed from the queue to the engine
  req_t req;
  logic req_valid;
  logic req_pop;

  ptil_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_wind_speed(in_wind_speed),
    .in_wind_angle(in_wind_angle),
    .in_entry_time(in_entry_time),
    .req_valid    (req_valid),
    .req_pop      (req_pop),
    .req          (req)
  );

  // Table storage, search, edit and interpolation
  ptil_engine #(
    .MAX_ROWS           (MAX_ROWS),
    .MAX_ENTRIES_PER_ROW(MAX_ENTRIES_PER_ROW)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req_valid),
    .req_pop        (req_pop),
    .req            (req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_time(out_result_time),
    .out_status     (out_status)
  );

endmodule
`default_nettype wire
